// ===== rtl/code_record_header_parser_unit_macros.svh =====
// assertion macros for the record header parser
// the asserting module must have clk and rst_n in scope
`ifndef CODE_RECORD_HEADER_PARSER_UNIT_MACROS_SVH
`define CODE_RECORD_HEADER_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define CRHP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crhp assertion failed");

`define CRHP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crhp assertion failed");

`else

`define CRHP_ASSERT_IMP(lbl, ante, cons)

`define CRHP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/crhp_pkg.sv =====
package crhp_pkg;

    localparam logic [3:0] PREFIX_RESET   = 4'd4;
    localparam logic [7:0] SHORT_SIZE_MAX = 8'hdf;
    localparam logic [7:0] COUNT_ESCAPE   = 8'hff;
    localparam logic [1:0] COUNT_EXTRA    = 2'd3;
    localparam logic [2:0] SEL_SHORT_MAX  = 3'd5;
    localparam logic [2:0] SEL_SIZE16     = 3'd6;
    localparam logic [2:0] SIZE16_BYTES   = 3'd2;
    localparam logic [2:0] WORD32_BYTES   = 3'd4;
    localparam logic [2:0] CLAUSE_VARINTS = 3'd6;

    typedef enum logic [6:0] {
        PH_PREFIX = 7'b0000001,
        PH_HEADER = 7'b0000010,
        PH_SIZE   = 7'b0000100,
        PH_COUNT1 = 7'b0001000,
        PH_COUNT4 = 7'b0010000,
        PH_BODY   = 7'b0100000,
        PH_CLAUSE = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [31:0] record_start;
        logic [31:0] record_length;
        logic [3:0]  body_offset;
        logic [31:0] body_size;
        logic [31:0] clause_count;
    } rec_t;

endpackage

// ===== rtl/crhp_parser.sv =====
`include "code_record_header_parser_unit_macros.svh"

module crhp_parser
    import crhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       section_start,
    output logic       emit,
    output rec_t       rec
);

    logic [3:0]  prefix_bytes_reg;
    phase_t      phase_reg, phase_next;
    logic [2:0]  fbi_reg, fbi_next;
    logic [2:0]  ssel_reg, ssel_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] count_reg, count_next;
    logic [3:0]  hlen_reg, hlen_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] crs_reg, crs_next;
    logic [31:0] body_reg, body_next;
    logic [31:0] clauses_reg, clauses_next;
    logic [2:0]  vi_reg, vi_next;
    logic [3:0]  prefix_reg, prefix_next;
    logic [31:0] pos_cur;
    logic        done;

    always_comb
    begin
        logic        run;
        logic        after_size;
        logic        finish;
        logic [31:0] lane;

        phase_next   = phase_reg;
        fbi_next     = fbi_reg;
        ssel_next    = ssel_reg;
        size_next    = size_reg;
        count_next   = count_reg;
        hlen_next    = hlen_reg;
        crs_next     = crs_reg;
        body_next    = body_reg;
        clauses_next = clauses_reg;
        vi_next      = vi_reg;
        prefix_next  = prefix_reg;
        pos_cur      = pos_reg;
        run          = 1'b1;
        after_size   = 1'b0;
        finish       = 1'b0;
        done         = 1'b0;

        if (section_start)
        begin
            phase_next  = PH_PREFIX;
            prefix_next = prefix_bytes_reg;
            pos_cur     = '0;
            fbi_next    = '0;
            vi_next     = '0;
        end
        pos_next = pos_cur + 32'd1;
        lane     = {24'd0, data_byte} << {fbi_next[1:0], 3'b000};

        if (phase_next == PH_PREFIX)
        begin
            if (prefix_next != 4'd0)
            begin
                prefix_next = prefix_next - 4'd1;
                if (prefix_next == 4'd0)
                begin
                    phase_next = PH_HEADER;
                end
                run = 1'b0;
            end
            else
            begin
                // zero prefix: this byte is already a header
                phase_next = PH_HEADER;
            end
        end

        if (run)
        begin
            unique case (phase_next)
                PH_SIZE:
                begin
                    hlen_next = hlen_next + 4'd1;
                    if (ssel_next <= SEL_SHORT_MAX)
                    begin
                        size_next  = {21'd0, ssel_next, data_byte};
                        after_size = 1'b1;
                    end
                    else
                    begin
                        size_next = size_next | lane;
                        fbi_next  = fbi_next + 3'd1;
                        if (fbi_next == ((ssel_next == SEL_SIZE16) ? SIZE16_BYTES
                                                                   : WORD32_BYTES))
                        begin
                            after_size = 1'b1;
                        end
                    end
                end
                PH_COUNT1:
                begin
                    hlen_next = hlen_next + 4'd1;
                    if (data_byte == COUNT_ESCAPE)
                    begin
                        count_next = '0;
                        fbi_next   = '0;
                        phase_next = PH_COUNT4;
                    end
                    else
                    begin
                        count_next = {24'd0, data_byte};
                        finish     = 1'b1;
                    end
                end
                PH_COUNT4:
                begin
                    hlen_next  = hlen_next + 4'd1;
                    count_next = count_next | lane;
                    fbi_next   = fbi_next + 3'd1;
                    if (fbi_next >= WORD32_BYTES)
                    begin
                        finish = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    body_next = body_next - 32'd1;
                    if (body_next == 32'd0)
                    begin
                        if (clauses_next == 32'd0)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            vi_next    = '0;
                            phase_next = PH_CLAUSE;
                        end
                    end
                end
                PH_CLAUSE:
                begin
                    // a set top bit keeps the varint open
                    if (!data_byte[7])
                    begin
                        vi_next = vi_next + 3'd1;
                        if (vi_next >= CLAUSE_VARINTS)
                        begin
                            vi_next      = '0;
                            clauses_next = clauses_next - 32'd1;
                            if (clauses_next == 32'd0)
                            begin
                                done = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    crs_next   = pos_cur;
                    hlen_next  = 4'd1;
                    fbi_next   = '0;
                    count_next = '0;
                    if (data_byte <= SHORT_SIZE_MAX)
                    begin
                        ssel_next = '0;
                        size_next = {24'd0, data_byte};
                        finish    = 1'b1;
                    end
                    else
                    begin
                        ssel_next  = data_byte[2:0];
                        count_next = {30'd0, data_byte[4:3]};
                        size_next  = '0;
                        phase_next = PH_SIZE;
                    end
                end
            endcase
        end

        if (after_size)
        begin
            if (count_next == {30'd0, COUNT_EXTRA})
            begin
                phase_next = PH_COUNT1;
            end
            else
            begin
                finish = 1'b1;
            end
        end

        if (finish)
        begin
            body_next    = size_next;
            clauses_next = count_next;
            vi_next      = '0;
            if (body_next != 32'd0)
            begin
                phase_next = PH_BODY;
            end
            else if (clauses_next != 32'd0)
            begin
                phase_next = PH_CLAUSE;
            end
            else
            begin
                done = 1'b1;
            end
        end

        if (done)
        begin
            phase_next = PH_HEADER;
        end
    end

    assign emit              = accept && done;
    assign rec.record_start  = crs_next;
    assign rec.record_length = pos_cur - crs_next + 32'd1;
    assign rec.body_offset   = hlen_next;
    assign rec.body_size     = size_next;
    assign rec.clause_count  = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_bytes_reg <= PREFIX_RESET;
        end
        else if (cfg_wr_en)
        begin
            prefix_bytes_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PREFIX;
            fbi_reg     <= '0;
            ssel_reg    <= '0;
            size_reg    <= '0;
            count_reg   <= '0;
            hlen_reg    <= '0;
            pos_reg     <= '0;
            crs_reg     <= '0;
            body_reg    <= '0;
            clauses_reg <= '0;
            vi_reg      <= '0;
            prefix_reg  <= PREFIX_RESET;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            fbi_reg     <= fbi_next;
            ssel_reg    <= ssel_next;
            size_reg    <= size_next;
            count_reg   <= count_next;
            hlen_reg    <= hlen_next;
            pos_reg     <= pos_next;
            crs_reg     <= crs_next;
            body_reg    <= body_next;
            clauses_reg <= clauses_next;
            vi_reg      <= vi_next;
            prefix_reg  <= prefix_next;
        end
    end

    `CRHP_ASSERT_NXT(a_emit_to_header, emit, phase_reg == PH_HEADER)
    `CRHP_ASSERT_IMP(a_prefix_left, phase_reg == PH_PREFIX, prefix_reg != 4'd0)
    `CRHP_ASSERT_IMP(a_body_left, phase_reg == PH_BODY, body_reg != 32'd0)
    `CRHP_ASSERT_IMP(a_clause_left, phase_reg == PH_CLAUSE, clauses_reg != 32'd0)

endmodule

// ===== rtl/crhp_queue.sv =====
`include "code_record_header_parser_unit_macros.svh"

module crhp_queue
    import crhp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output rec_t out_rec
);

    rec_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_rec   = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    `CRHP_ASSERT_IMP(a_no_overflow, push, !full)
    `CRHP_ASSERT_NXT(a_empty_push, push && count_reg == 2'd0, out_valid && out_rec == $past(push_rec))
    `CRHP_ASSERT_NXT(a_pop_drains, pop && !push, count_reg == $past(count_reg) - 2'd1)

endmodule

// ===== rtl/code_record_header_parser_unit.sv =====
// channel | direction | payload                                       | handshake
// input   | in        | data_byte, section_start                      | in_valid / in_stall
// output  | out       | record_start, record_length, body_offset,     | out_valid / out_stall
//         |           | body_size, clause_count                       |
// config  | in        | cfg_wr_data (prefix_bytes)                    | cfg_wr_en
//
// one byte accepted per cycle while in_stall is low; the parser state updates in that cycle
// a record result enters a two-entry queue on its last byte and is held there from the next cycle
// in_stall rises only when both queue entries hold results not yet taken
// reset (async, rst_n low) puts the parser in prefix skip with prefix_bytes = 4
module code_record_header_parser_unit
    import crhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        section_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] record_start,
    output logic [31:0] record_length,
    output logic [3:0]  body_offset,
    output logic [31:0] body_size,
    output logic [31:0] clause_count
);

    logic accept;
    logic emit;
    logic full;
    rec_t new_rec;
    rec_t head_rec;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    crhp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .accept        (accept),
        .data_byte     (data_byte),
        .section_start (section_start),
        .emit          (emit),
        .rec           (new_rec)
    );

    crhp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_rec  (new_rec),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rec   (head_rec)
    );

    assign record_start  = head_rec.record_start;
    assign record_length = head_rec.record_length;
    assign body_offset   = head_rec.body_offset;
    assign body_size     = head_rec.body_size;
    assign clause_count  = head_rec.clause_count;

endmodule
